### rtl/pdr_pkg.sv
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared types, codes and constants of the dead-reckoning pose tracker.
// ----------------------------------------------------------------------------
package pdr_pkg;

  // Command codes
  localparam logic [1:0] KIND_ROTATE  = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_ELEVATE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MOVE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLIMB = 2'd2;

  // Accumulator targets
  localparam logic [1:0] ACC_X = 2'd0;
  localparam logic [1:0] ACC_Y = 2'd1;
  localparam logic [1:0] ACC_Z = 2'd2;

  localparam int unsigned POS_OUT_W        = 48;
  localparam int unsigned CORDIC_MAX_STEPS = 24;
  localparam int unsigned CORDIC_W         = 34;  // Q2.30 plus headroom
  localparam int unsigned ANGLE_W          = 33;  // residual angle, 1/2^32 turn
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh26DD3B6A;
  localparam logic signed [CORDIC_W-1:0] ROUND_HALF  = 34'sd16384;

  typedef struct packed {
    logic [1:0]         kind;
    logic               turn_left;
    logic [15:0]        turn_amount;
    logic signed [31:0] distance;
  } pdr_in_t;

  typedef struct packed {
    logic [15:0]        heading_out;
    logic signed [47:0] x_out;
    logic signed [47:0] y_out;
    logic signed [47:0] z_out;
  } pdr_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       turn;
    logic       cordic_step;
    logic       round;
    logic       mul_en;
    logic       mul_sin;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       out_load;
  } pdr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cordic_last;
  } pdr_sts_t;

  // atan(2^-i) in 1/2^32 turn
  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/pose_dead_reckoning.sv
// ----------------------------------------------------------------------------
// pose_dead_reckoning
// Dead-reckoning pose tracker: heading plus x, y, z position.
// ----------------------------------------------------------------------------
// Each input word is one movement command (rotate, advance or elevate) and
// produces exactly one output word holding the pose after the command.
// Rotate clamps to max_turn (0 = no limit) and wraps the 16-bit heading.
// Advance clamps to +- the horizontal move limit, computes cos/sin of the
// heading with an iterative CORDIC and adds the rounded distance*cos and
// distance*sin to x and y; elevate clamps to +-max_climb and adds to z.
// Positions saturate at the signed POSITION_BITS range; outputs show their
// low 48 bits. Kind 3 changes nothing. One command is in flight at a time:
// a rotate passes through the turn state and an elevate through the climb
// state before the output word is loaded; kind 3 goes straight to it; an
// advance runs the single CORDIC stage doing one micro-rotation per cycle,
// followed by rounding and the shared 32x16 multiplier used once for x and
// once for y. The next command is taken the cycle after the word is loaded.
// A finished word waits in the output register while the next command is
// accepted; a stalled word holds that command in its final cycle. Limit
// registers are written through cfg_we_i / cfg_addr_i / cfg_data_i; the user
// writes them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pose_dead_reckoning #(
  parameter int unsigned CORDIC_STEPS  = 16,
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config
  input  logic                           cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [pdr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // command words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pdr_pkg::pdr_in_t               in_word_i,
  // pose words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pdr_pkg::pdr_out_t              out_word_o
);
  import pdr_pkg::*;

  pdr_cmd_t cmd;
  pdr_sts_t sts;

  pdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (in_word_i.kind),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pdr_datapath #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

### rtl/pdr_datapath.sv
// ----------------------------------------------------------------------------
// pdr_datapath
// Pose and limit registers, iterative CORDIC, shared multiplier and
// saturating accumulator, output word register.
// ----------------------------------------------------------------------------
module pdr_datapath #(
  parameter int unsigned CORDIC_STEPS  = 16,
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  pdr_pkg::pdr_in_t                   in_word_i,
  input  pdr_pkg::pdr_cmd_t                  cmd_i,
  output pdr_pkg::pdr_sts_t                  sts_o,
  output pdr_pkg::pdr_out_t                  out_word_o
);
  import pdr_pkg::*;

  localparam int unsigned StepsEff =
    (CORDIC_STEPS < CORDIC_MAX_STEPS) ? CORDIC_STEPS : CORDIC_MAX_STEPS;
  localparam int unsigned IterW = $clog2(StepsEff);
  localparam int unsigned PB    = POSITION_BITS;

  // Limits
  logic [15:0] max_turn_q;
  logic [30:0] max_move_q, max_climb_q;

  // Pose
  logic [15:0]   heading_q, heading_d;
  logic [PB-1:0] pos_x_q, pos_y_q, pos_z_q;

  // Command operands
  logic               left_q;
  logic [15:0]        amount_q;
  logic signed [31:0] dist_q, dist_d;

  // CORDIC
  logic signed [CORDIC_W-1:0] cx_q, cy_q, cx_d, cy_d, xs, ys;
  logic signed [ANGLE_W-1:0]  cz_q, cz_d, atan_s;
  logic [1:0]                 quad_q;
  logic [IterW-1:0]           iter_q;
  logic [15:0]                ang_p, resid;
  logic [1:0]                 quad_d;

  // Rounded cos / sin
  logic signed [15:0] cos_q, sin_q, cos_d, sin_d;
  logic signed [CORDIC_W-1:0] xr, yr;
  logic signed [18:0] cr19, sr19;
  logic signed [19:0] cr, sr;

  // Multiplier and accumulator
  logic signed [47:0] prod_q;
  logic signed [15:0] mul_opnd;
  logic signed [PB-1:0] acc_a;
  logic signed [32:0]   acc_b;
  logic                 acc_cin;
  logic signed [PB:0]   a_ext, b_ext, sum;
  logic [PB:0]          cin_ext;
  logic [PB-1:0]        acc_res;

  // Clamp
  logic [30:0]        lim;
  logic signed [32:0] lim_s, nlim_s, d_e;
  logic [15:0]        mag;

  pdr_out_t out_q;

  function automatic logic signed [15:0] sat_q15(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  // Distance clamp at load
  always_comb begin
    lim    = (in_word_i.kind == KIND_ADVANCE) ? max_move_q : max_climb_q;
    lim_s  = {2'b00, lim};
    nlim_s = -lim_s;
    d_e    = 33'(in_word_i.distance);
    dist_d = in_word_i.distance;
    if (lim != '0) begin
      if (d_e > lim_s) begin
        dist_d = 32'(lim_s);
      end else if (d_e < nlim_s) begin
        dist_d = 32'(nlim_s);
      end
    end
  end

  // Quarter-turn reduction of the current heading
  always_comb begin
    ang_p  = heading_q + 16'h2000;
    quad_d = ang_p[15:14];
    resid  = heading_q - {quad_d, 14'b0};
  end

  // Rotate
  always_comb begin
    mag = amount_q;
    if (max_turn_q != '0 && amount_q > max_turn_q) begin
      mag = max_turn_q;
    end
    heading_d = left_q ? heading_q + mag : heading_q - mag;
  end

  // One CORDIC micro-rotation
  always_comb begin
    xs     = cx_q >>> iter_q;
    ys     = cy_q >>> iter_q;
    atan_s = ANGLE_W'(atan_turn32(5'(iter_q)));
    if (!cz_q[ANGLE_W-1]) begin
      cx_d = cx_q - ys;
      cy_d = cy_q + xs;
      cz_d = cz_q - atan_s;
    end else begin
      cx_d = cx_q + ys;
      cy_d = cy_q - xs;
      cz_d = cz_q + atan_s;
    end
  end

  assign sts_o.cordic_last = (iter_q == IterW'(StepsEff - 1));

  // Round to Q1.15, undo the quarter-turn reduction, saturate
  always_comb begin
    xr   = cx_q + ROUND_HALF;
    yr   = cy_q + ROUND_HALF;
    cr19 = xr[33:15];
    sr19 = yr[33:15];
    cr   = 20'(cr19);
    sr   = 20'(sr19);
    unique case (quad_q)
      2'd0: begin cos_d = sat_q15(cr);  sin_d = sat_q15(sr);  end
      2'd1: begin cos_d = sat_q15(-sr); sin_d = sat_q15(cr);  end
      2'd2: begin cos_d = sat_q15(-cr); sin_d = sat_q15(-sr); end
      2'd3: begin cos_d = sat_q15(sr);  sin_d = sat_q15(-cr); end
    endcase
  end

  assign mul_opnd = cmd_i.mul_sin ? sin_q : cos_q;

  // Shared saturating adder; the product is rounded through the carry-in
  always_comb begin
    unique case (cmd_i.acc_sel)
      ACC_X:   acc_a = pos_x_q;
      ACC_Y:   acc_a = pos_y_q;
      default: acc_a = pos_z_q;
    endcase
    if (cmd_i.acc_sel == ACC_Z) begin
      acc_b   = 33'(dist_q);
      acc_cin = 1'b0;
    end else begin
      acc_b   = prod_q[47:15];
      acc_cin = prod_q[14];
    end
    a_ext   = (PB+1)'(acc_a);
    b_ext   = (PB+1)'(acc_b);
    cin_ext = (PB+1)'(acc_cin);
    sum     = a_ext + b_ext + cin_ext;
    if (sum[PB] != sum[PB-1]) begin
      acc_res = sum[PB] ? {1'b1, {(PB-1){1'b0}}} : {1'b0, {(PB-1){1'b1}}};
    end else begin
      acc_res = sum[PB-1:0];
    end
  end

  // Limits and pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_turn_q  <= '0;
      max_move_q  <= '0;
      max_climb_q <= '0;
      heading_q   <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_MAX_TURN:  max_turn_q  <= cfg_data_i[15:0];
          CFG_MAX_MOVE:  max_move_q  <= cfg_data_i;
          CFG_MAX_CLIMB: max_climb_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.turn) begin
        heading_q <= heading_d;
      end
      if (cmd_i.acc_en) begin
        unique case (cmd_i.acc_sel)
          ACC_X:   pos_x_q <= acc_res;
          ACC_Y:   pos_y_q <= acc_res;
          default: pos_z_q <= acc_res;
        endcase
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_q   <= in_word_i.turn_left;
      amount_q <= in_word_i.turn_amount;
      dist_q   <= dist_d;
      quad_q   <= quad_d;
      cx_q     <= CORDIC_GAIN;
      cy_q     <= '0;
      cz_q     <= ANGLE_W'($signed({resid, 16'b0}));
      iter_q   <= '0;
    end else if (cmd_i.cordic_step) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      cz_q   <= cz_d;
      iter_q <= iter_q + 1'b1;
    end
    if (cmd_i.round) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= 48'(dist_q) * 48'(mul_opnd);
    end
    if (cmd_i.out_load) begin
      out_q.heading_out <= heading_q;
      out_q.x_out       <= POS_OUT_W'(pos_x_q);
      out_q.y_out       <= POS_OUT_W'(pos_y_q);
      out_q.z_out       <= POS_OUT_W'(pos_z_q);
    end
  end

  assign out_word_o = out_q;

endmodule

### rtl/pdr_ctrl.sv
// ----------------------------------------------------------------------------
// pdr_ctrl
// Sequencer: accepts a command word, steps the datapath, hands off the
// result word to the output register.
// ----------------------------------------------------------------------------
module pdr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        kind_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pdr_pkg::pdr_sts_t sts_i,
  output pdr_pkg::pdr_cmd_t cmd_o
);
  import pdr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_TURN   = 4'd1;
  localparam logic [3:0] S_CLIMB  = 4'd2;
  localparam logic [3:0] S_CORDIC = 4'd3;
  localparam logic [3:0] S_ROUND  = 4'd4;
  localparam logic [3:0] S_MUL_X  = 4'd5;
  localparam logic [3:0] S_ACC_X  = 4'd6;
  localparam logic [3:0] S_ACC_Y  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.acc_sel = ACC_Z;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (kind_i)
            KIND_ROTATE:  state_d = S_TURN;
            KIND_ADVANCE: state_d = S_CORDIC;
            KIND_ELEVATE: state_d = S_CLIMB;
            default:      state_d = S_OUT;
          endcase
        end
      end
      S_TURN: begin
        cmd_o.turn = 1'b1;
        state_d    = S_OUT;
      end
      S_CLIMB: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = ACC_Z;
        state_d       = S_OUT;
      end
      S_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) begin
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = S_MUL_X;
      end
      S_MUL_X: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_ACC_X;
      end
      S_ACC_X: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = ACC_X;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sin = 1'b1;
        state_d       = S_ACC_Y;
      end
      S_ACC_Y: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = ACC_Y;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dead-reckoning pose tracker.
// ----------------------------------------------------------------------------
// The bench drives movement command words and checks every pose word that
// comes back against its own bit-exact model or a pose typed in by hand. That
// model has its own heading, positions and limit registers, and its own
// CORDIC for cos/sin. The run has these parts:
//   - a short scripted part: field extremes, every command, quarter-turn
//     boundaries, the unused command code and limit clamping;
//   - five random phases, each under its own set of limits (the lowest,
//     the highest, random, moderate, and back to unlimited).
// Both sides idle and stall at random. The output side holds off once for a
// long stretch, so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  import pdr_pkg::*;

  localparam int unsigned CORDIC_ITERS = 16;
  localparam int unsigned POS_BITS     = 48;
  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RAND_PHASES  = 5;
  localparam int unsigned PHASE_WORDS  = 390;
  localparam int unsigned HOLD_AFTER   = 600;      // poses seen before the long hold
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 40;       // longer than an advance takes
  localparam int unsigned LIMIT_CYCLES = 2000000;

  // Command code the block leaves unused: it must move nothing
  localparam logic [1:0] KIND_NOP = 2'd3;

  localparam longint POS_HI = (longint'(1) <<< (POS_BITS - 1)) - 1;
  localparam longint POS_LO = -POS_HI - 1;

  // CORDIC start value (gain compensation, Q2.30)
  localparam longint CORDIC_X0 = 64'sh26DD3B6A;
  // atan(2^-i) in 1/2^32 turn, entry i at bits [32*i +: 32]
  localparam logic [16*32-1:0] ATAN_TURN = {
    32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
    32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
    32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };

  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                 typed;
    pdr_in_t              cmd;
    pdr_out_t             pose;
  } script_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  pdr_in_t               in_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  pdr_out_t              out_word_o;

  // model state: limits and pose
  logic [15:0]           cfg_turn_lim;
  logic [CFG_DATA_W-1:0] cfg_adv_lim;
  logic [CFG_DATA_W-1:0] cfg_climb_lim;
  logic [15:0]           pose_heading;
  longint                pose_x;
  longint                pose_y;
  longint                pose_z;

  pdr_out_t    pending_poses[$];
  script_row_t script[$];
  int unsigned poses_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;   // no idling on either side while set

  pose_dead_reckoning #(
    .CORDIC_STEPS (CORDIC_ITERS),
    .POSITION_BITS(POS_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  function automatic longint clip_q15(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Snap to the nearest quarter turn, run the CORDIC on the residual
  // (+-1/8 turn), round to Q1.15, then rotate back by the quarter.
  function automatic void heading_cos_sin(input logic [15:0] ang,
                                          output longint c, output longint s);
    logic [15:0] near;
    logic [1:0]  quad;
    logic [15:0] resid;
    longint      x, y, z, xs, ys, cr, sr;
    near  = ang + 16'h2000;
    quad  = near[15:14];
    resid = ang - {quad, 14'd0};
    z = longint'($signed(resid)) <<< 16;
    x = CORDIC_X0;
    y = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURN[32*i +: 32]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURN[32*i +: 32]);
      end
    end
    cr = (x + 16384) >>> 15;
    sr = (y + 16384) >>> 15;
    case (quad)
      2'd0: begin c = cr;  s = sr;  end
      2'd1: begin c = -sr; s = cr;  end
      2'd2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
    c = clip_q15(c);
    s = clip_q15(s);
  endfunction

  function automatic longint clamp_move(input longint d, input longint lim);
    if (lim != 0) begin
      if (d > lim) d = lim;
      if (d < -lim) d = -lim;
    end
    return d;
  endfunction

  function automatic longint clip_add(input longint a, input longint b);
    if (b > 0 && a > POS_HI - b) return POS_HI;
    if (b < 0 && a < POS_LO - b) return POS_LO;
    return a + b;
  endfunction

  // Applies one command to the model pose and returns the pose word
  function automatic pdr_out_t move_pose(input pdr_in_t c);
    logic [15:0] mag;
    longint      d, cv, sv;
    pdr_out_t    p;
    d = longint'($signed(c.distance));
    case (c.kind)
      KIND_ROTATE: begin
        mag = c.turn_amount;
        if (cfg_turn_lim != 0 && mag > cfg_turn_lim) mag = cfg_turn_lim;
        pose_heading = c.turn_left ? pose_heading + mag : pose_heading - mag;
      end
      KIND_ADVANCE: begin
        d = clamp_move(d, longint'(cfg_adv_lim));
        heading_cos_sin(pose_heading, cv, sv);
        pose_x = clip_add(pose_x, (d * cv + 16384) >>> 15);
        pose_y = clip_add(pose_y, (d * sv + 16384) >>> 15);
      end
      KIND_ELEVATE: begin
        d = clamp_move(d, longint'(cfg_climb_lim));
        pose_z = clip_add(pose_z, d);
      end
      default: ;
    endcase
    p.heading_out = pose_heading;
    p.x_out       = pose_x[POS_OUT_W-1:0];
    p.y_out       = pose_y[POS_OUT_W-1:0];
    p.z_out       = pose_z[POS_OUT_W-1:0];
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly back to back, often a short gap, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  function automatic script_row_t cmd_row(input logic [1:0] k, input logic l,
                                          input logic [15:0] a,
                                          input logic signed [31:0] d);
    script_row_t r;
    r = '0;
    r.cmd.kind        = k;
    r.cmd.turn_left   = l;
    r.cmd.turn_amount = a;
    r.cmd.distance    = d;
    return r;
  endfunction

  // Command row with the pose typed in
  function automatic script_row_t pose_row(input logic [1:0] k, input logic l,
                                           input logic [15:0] a,
                                           input logic signed [31:0] d,
                                           input logic [15:0] h,
                                           input logic signed [47:0] x,
                                           input logic signed [47:0] y,
                                           input logic signed [47:0] z);
    script_row_t r;
    r = cmd_row(k, l, a, d);
    r.typed            = 1'b1;
    r.pose.heading_out = h;
    r.pose.x_out       = x;
    r.pose.y_out       = y;
    r.pose.z_out       = z;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    script_row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Random command. Amounts and distances are aimed at the current limits
  // as often as at the full field range.
  function automatic pdr_in_t random_cmd();
    pdr_in_t     c;
    int unsigned roll;
    longint      lim, sgn;
    roll = $urandom_range(0, 19);
    if (roll < 6) c.kind = KIND_ROTATE;
    else if (roll < 13) c.kind = KIND_ADVANCE;
    else if (roll < 19) c.kind = KIND_ELEVATE;
    else c.kind = KIND_NOP;
    c.turn_left = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: c.turn_amount = 16'($urandom);
      1: c.turn_amount = 16'($urandom_range(0, 64));
      2: c.turn_amount = cfg_turn_lim + 16'($urandom_range(0, 2)) - 16'd1;
      default: c.turn_amount = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    lim = longint'((c.kind == KIND_ELEVATE) ? cfg_climb_lim : cfg_adv_lim);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 4))
      0: c.distance = 32'($urandom);
      1: c.distance = 32'(longint'($urandom_range(0, 8000)) - 4000);
      2: c.distance = 32'(sgn * (lim + longint'($urandom_range(0, 2)) - 1));
      3: c.distance = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: c.distance = 32'(sgn * longint'($urandom_range(0, 1 << 20)));
    endcase
    return c;
  endfunction

  // One command word. Entered and left at a falling edge. The model is
  // advanced when the word goes out, as it is held until accepted.
  task automatic send_cmd(input pdr_in_t c, input bit typed, input pdr_out_t typed_pose);
    int unsigned gap;
    pdr_out_t    predicted;
    gap = pick_idle();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= c;
    predicted = move_pose(c);
    pending_poses.push_back(typed ? typed_pose : predicted);
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  // Limit write, only once every pose word is back and the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_poses.size() != 0);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_TURN:  cfg_turn_lim  = val[15:0];
      CFG_MAX_MOVE:  cfg_adv_lim   = val;
      CFG_MAX_CLIMB: cfg_climb_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [15:0] turn, input logic [CFG_DATA_W-1:0] adv,
                            input logic [CFG_DATA_W-1:0] climb);
    write_reg(CFG_MAX_TURN, CFG_DATA_W'(turn));
    write_reg(CFG_MAX_MOVE, adv);
    write_reg(CFG_MAX_CLIMB, climb);
  endtask

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  initial begin : stimulus
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    cfg_turn_lim  = '0;
    cfg_adv_lim   = '0;
    cfg_climb_lim = '0;
    pose_heading  = '0;
    pose_x        = 0;
    pose_y        = 0;
    pose_z        = 0;
    rst_ni        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Scripted part, limits at their reset value (no limit).
    // Straight after reset the pose can be written down by hand.
    script.push_back(pose_row(KIND_ROTATE, 1'b1, 16'h0000, 32'sd0, 16'h0000, 0, 0, 0));
    script.push_back(pose_row(KIND_ELEVATE, 1'b0, 16'h0000, 32'sh7FFFFFFF,
                              16'h0000, 0, 0, 48'sd2147483647));
    script.push_back(pose_row(KIND_ELEVATE, 1'b1, 16'hFFFF, 32'sh80000000,
                              16'h0000, 0, 0, -48'sd1));
    // unused command code moves nothing
    script.push_back(pose_row(KIND_NOP, 1'b1, 16'hFFFF, 32'sh7FFFFFFF,
                              16'h0000, 0, 0, -48'sd1));
    script.push_back(pose_row(KIND_ADVANCE, 1'b0, 16'hFFFF, 32'sd0,
                              16'h0000, 0, 0, -48'sd1));
    // heading wraps both ways; rotate ignores the distance
    script.push_back(pose_row(KIND_ROTATE, 1'b1, 16'hFFFF, 32'sd0, 16'hFFFF, 0, 0, -48'sd1));
    script.push_back(pose_row(KIND_ROTATE, 1'b0, 16'hFFFF, 32'sd0, 16'h0000, 0, 0, -48'sd1));
    script.push_back(pose_row(KIND_ROTATE, 1'b0, 16'h0001, 32'sh80000000,
                              16'hFFFF, 0, 0, -48'sd1));
    script.push_back(pose_row(KIND_ROTATE, 1'b1, 16'h0001, 32'sh7FFFFFFF,
                              16'h0000, 0, 0, -48'sd1));
    // advances around the quarter-turn snapping points
    script.push_back(cmd_row(KIND_ADVANCE, 1'b0, 16'h0000, 32'sh7FFFFFFF));
    script.push_back(cmd_row(KIND_ADVANCE, 1'b1, 16'h0000, 32'sh80000000));
    script.push_back(cmd_row(KIND_ROTATE, 1'b1, 16'h1FFF, 32'sd0));
    script.push_back(cmd_row(KIND_ADVANCE, 1'b0, 16'h0000, 32'sd1000000));
    script.push_back(cmd_row(KIND_ROTATE, 1'b1, 16'h0001, 32'sd0));
    script.push_back(cmd_row(KIND_ADVANCE, 1'b0, 16'h0000, -32'sd1000000));
    script.push_back(cmd_row(KIND_ROTATE, 1'b1, 16'h2000, 32'sd0));
    script.push_back(cmd_row(KIND_ADVANCE, 1'b0, 16'h0000, 32'sh7FFFFFFF));
    script.push_back(cmd_row(KIND_ROTATE, 1'b1, 16'h4000, 32'sd0));
    script.push_back(cmd_row(KIND_ADVANCE, 1'b0, 16'h0000, 32'sh7FFFFFFF));
    script.push_back(cmd_row(KIND_ROTATE, 1'b1, 16'h4000, 32'sd0));
    script.push_back(cmd_row(KIND_ADVANCE, 1'b0, 16'h0000, 32'sh80000000));
    // clamping of each kind of move
    script.push_back(reg_row(CFG_MAX_TURN, 31'h100));
    script.push_back(cmd_row(KIND_ROTATE, 1'b1, 16'hFFFF, 32'sd0));
    script.push_back(reg_row(CFG_MAX_MOVE, 31'd1000));
    script.push_back(cmd_row(KIND_ADVANCE, 1'b0, 16'h0000, 32'sh80000000));
    script.push_back(reg_row(CFG_MAX_CLIMB, 31'd7));
    script.push_back(cmd_row(KIND_ELEVATE, 1'b0, 16'h0000, 32'sh80000000));
    script.push_back(cmd_row(KIND_ELEVATE, 1'b0, 16'h0000, 32'sh7FFFFFFF));

    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].reg_idx, script[i].reg_val);
      else send_cmd(script[i].cmd, script[i].typed, script[i].pose);
    end

    // Random phases, each under its own limits
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_limits(16'd1, 31'd1, 31'd1);
        1: set_limits(16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        2: set_limits(16'($urandom_range(1, 16'hFFFF)), 31'($urandom_range(1, 1 << 20)),
                      31'($urandom_range(1, 31'h7FFFFFFF)));
        3: set_limits(16'h0800, 31'd20000, 31'd256);
        default: set_limits(16'd0, 31'd0, 31'd0);
      endcase
      quiet = (ph == 3);   // one phase runs without any idling
      repeat (PHASE_WORDS) send_cmd(random_cmd(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("pose_dead_reckoning test passed");
    end else begin
      $display("pose_dead_reckoning test failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Pose side: random stalls plus one long hold while commands keep coming
  // --------------------------------------------------------------------------
  initial begin : pose_stall
    int unsigned run_len;
    bit          held;
    run_len     = 0;
    held        = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && poses_checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
        run_len = 4;
      end else if (run_len != 0) begin
        run_len--;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 3) == 0);
        run_len = pick_idle();
      end
    end
  end

  task automatic report_field(input string fld, input logic signed [63:0] want,
                              input logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, fld, want, got);
    end
  endtask

  // Every accepted pose word is checked against the oldest expected pose
  always @(posedge clk_i) begin : pose_check
    pdr_out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_poses.size() == 0) begin
        mismatches++;
        $display("%0t ns: pose word %h with nothing expected", $time, out_word_o);
      end else begin
        want = pending_poses.pop_front();
        report_field("heading", {48'd0, want.heading_out}, {48'd0, out_word_o.heading_out});
        report_field("x", want.x_out, out_word_o.x_out);
        report_field("y", want.y_out, out_word_o.y_out);
        report_field("z", want.z_out, out_word_o.z_out);
      end
      poses_checked++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("pose_dead_reckoning test failed");
      $finish;
    end
  end

endmodule
